// ===== sv/rip_route_table_engine_unit_assert.svh =====
// assertion macros shared by the checker
`ifndef RIP_ROUTE_TABLE_ENGINE_UNIT_ASSERT_SVH
`define RIP_ROUTE_TABLE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define RRTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrte check failed");

// next-cycle implication
`define RRTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrte check failed");

`endif

// ===== sv/rrte_pkg.sv =====
`timescale 1ns / 1ps
package rrte_pkg;

    localparam int TABLE_DEPTH_DEF        = 32;
    localparam int ENTRIES_PER_PACKET_DEF = 25;

    localparam logic [4:0] UNREACH  = 5'd16;
    localparam logic [7:0] RIP_VER  = 8'd2;
    localparam logic [7:0] CMD_REQ  = 8'd1;
    localparam logic [7:0] CMD_RESP = 8'd2;

    localparam logic [1:0] REQ_RX      = 2'd0;
    localparam logic [1:0] REQ_TIMEOUT = 2'd1;
    localparam logic [1:0] REQ_SEND    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_VER_ERR = 2'd1;
    localparam logic [1:0] ST_CMD_ERR = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic [2:0] {
        OP_VER_ERR,
        OP_CMD_ERR,
        OP_DUMP,
        OP_UPDATE,
        OP_TIMEOUT,
        OP_NONE
    } op_e_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  rip_version;
        logic [7:0]  rip_command;
        logic [31:0] dest_addr;
        logic [31:0] dest_mask;
        logic [31:0] route_metric;
        logic [31:0] src_addr;
        logic [7:0]  iface;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_dest;
        logic [31:0] out_mask;
        logic [31:0] out_nexthop;
        logic [4:0]  out_metric;
        logic        out_valid;
        logic        packet_end;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] nexthop;
        logic [4:0]  hops;
        logic [7:0]  iface;
    } row_t;

    typedef struct packed {
        op_e_t       op;
        logic        met_ge16;
        row_t        row;
    } op_t;

    function automatic out_word_t make_word(logic [1:0] st, row_t r, logic v,
                                            logic pend, logic lst);
        out_word_t w;
        w.status      = st;
        w.out_dest    = v ? r.dest : 32'd0;
        w.out_mask    = v ? r.mask : 32'd0;
        w.out_nexthop = v ? r.nexthop : 32'd0;
        w.out_metric  = v ? r.hops : 5'd0;
        w.out_valid   = v;
        w.packet_end  = pend;
        w.last        = lst;
        return w;
    endfunction

endpackage

// ===== sv/rrte_front.sv =====
`timescale 1ns / 1ps
module rrte_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rrte_pkg::in_word_t in_data,
    output logic              push_valid,
    input  logic              push_ready,
    output rrte_pkg::op_t     push_data
);

    logic          f_valid_reg;
    logic          f_valid_next;
    rrte_pkg::op_t f_op_reg;
    rrte_pkg::op_t f_op_next;
    logic          accept;

    assign in_stall   = f_valid_reg && !push_ready;
    assign accept     = in_valid && !in_stall;
    assign push_valid = f_valid_reg;
    assign push_data  = f_op_reg;

    always_comb
    begin
        f_op_next.met_ge16    = in_data.route_metric >= 32'd16;
        f_op_next.row.dest    = in_data.dest_addr;
        f_op_next.row.mask    = in_data.dest_mask;
        f_op_next.row.nexthop = in_data.src_addr;
        f_op_next.row.iface   = in_data.iface;
        f_op_next.row.hops    = f_op_next.met_ge16 ? rrte_pkg::UNREACH
                                : 5'(in_data.route_metric[3:0]) + 5'd1;
        unique case (in_data.req_type)
            rrte_pkg::REQ_RX:
            begin
                if (in_data.rip_version != rrte_pkg::RIP_VER)
                    f_op_next.op = rrte_pkg::OP_VER_ERR;
                else if (in_data.rip_command == rrte_pkg::CMD_REQ)
                    f_op_next.op = rrte_pkg::OP_DUMP;
                else if (in_data.rip_command == rrte_pkg::CMD_RESP)
                    f_op_next.op = rrte_pkg::OP_UPDATE;
                else
                    f_op_next.op = rrte_pkg::OP_CMD_ERR;
            end
            rrte_pkg::REQ_TIMEOUT: f_op_next.op = rrte_pkg::OP_TIMEOUT;
            rrte_pkg::REQ_SEND:    f_op_next.op = rrte_pkg::OP_DUMP;
            default:               f_op_next.op = rrte_pkg::OP_NONE;
        endcase
        f_valid_next = accept ? 1'b1 : (push_ready ? 1'b0 : f_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            f_op_reg <= f_op_next;
    end

endmodule

// ===== sv/rrte_queue.sv =====
`timescale 1ns / 1ps
module rrte_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  rrte_pkg::op_t push_data,
    output logic          pop_valid,
    input  logic          pop,
    output rrte_pkg::op_t pop_data
);

    rrte_pkg::op_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = fill_reg != 2'd2;
    assign pop_valid  = fill_reg != 2'd0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/rrte_back.sv =====
`timescale 1ns / 1ps
module rrte_back
#(
    parameter int TABLE_DEPTH        = rrte_pkg::TABLE_DEPTH_DEF,
    parameter int ENTRIES_PER_PACKET = rrte_pkg::ENTRIES_PER_PACKET_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  rrte_pkg::op_t       q_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rrte_pkg::out_word_t out_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = $clog2(ENTRIES_PER_PACKET + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_END,
        S_FIN,
        S_TAIL,
        S_CLOSE
    } state_t;

    rrte_pkg::row_t      mem [TABLE_DEPTH];
    rrte_pkg::row_t      rd_row_reg;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    rrte_pkg::row_t      wr_row;

    state_t              state_reg, state_next;
    rrte_pkg::op_t       op_reg, op_next;
    logic [AW-1:0]       scan_reg, scan_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [PW-1:0]       pkt_reg, pkt_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_end_reg, pend_end_next;
    rrte_pkg::row_t      pend_row_reg, pend_row_next;
    logic                hit_reg, hit_next;
    rrte_pkg::row_t      hit_row_reg, hit_row_next;
    rrte_pkg::out_word_t res_reg, res_next;
    logic                ovalid_reg, ovalid_next;
    rrte_pkg::out_word_t oword_reg, oword_next;

    logic                out_free;
    logic                match;
    logic                send;
    logic [CW-1:0]       cm1;
    logic [PW-1:0]       pc1;
    rrte_pkg::row_t      upd_row;

    assign out_valid = ovalid_reg;
    assign out_data  = oword_reg;
    assign out_free  = !ovalid_reg || !out_stall;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign match     = (rd_row_reg.dest == op_reg.row.dest)
                       && (rd_row_reg.mask == op_reg.row.mask);
    assign send      = rd_row_reg.iface != op_reg.row.iface;
    assign cm1       = count_reg - CW'(1);
    assign pc1       = pkt_reg + PW'(1);

    always_comb
    begin
        upd_row = rd_row_reg;
        if (op_reg.met_ge16)
            upd_row.hops = rrte_pkg::UNREACH;
        else if (op_reg.row.hops < rd_row_reg.hops)
        begin
            upd_row.nexthop = op_reg.row.nexthop;
            upd_row.hops    = op_reg.row.hops;
            upd_row.iface   = op_reg.row.iface;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        scan_next       = scan_reg;
        count_next      = count_reg;
        pkt_next        = pkt_reg;
        pend_valid_next = pend_valid_reg;
        pend_end_next   = pend_end_reg;
        pend_row_next   = pend_row_reg;
        hit_next        = hit_reg;
        hit_row_next    = hit_row_reg;
        res_next        = res_reg;
        ovalid_next     = ovalid_reg && out_stall;
        oword_next      = oword_reg;
        wr_en           = 1'b0;
        wr_addr         = scan_reg;
        wr_row          = rd_row_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    op_next         = q_data;
                    pkt_next        = '0;
                    pend_valid_next = 1'b0;
                    hit_next        = 1'b0;
                    scan_next       = cm1[AW-1:0];
                    unique case (q_data.op)
                        rrte_pkg::OP_VER_ERR:
                        begin
                            res_next   = rrte_pkg::make_word(rrte_pkg::ST_VER_ERR, '0,
                                                             1'b0, 1'b0, 1'b1);
                            state_next = S_FIN;
                        end
                        rrte_pkg::OP_CMD_ERR:
                        begin
                            res_next   = rrte_pkg::make_word(rrte_pkg::ST_CMD_ERR, '0,
                                                             1'b0, 1'b0, 1'b1);
                            state_next = S_FIN;
                        end
                        rrte_pkg::OP_NONE:
                        begin
                            res_next   = rrte_pkg::make_word(rrte_pkg::ST_OK, '0,
                                                             1'b0, 1'b0, 1'b1);
                            state_next = S_FIN;
                        end
                        default:
                            state_next = (count_reg == '0) ? S_END : S_RD;
                    endcase
                end
            end
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                state_next = (scan_reg == '0) ? S_END : S_RD;
                scan_next  = scan_reg - AW'(1);
                unique case (op_reg.op)
                    rrte_pkg::OP_UPDATE:
                    begin
                        if (match)
                        begin
                            wr_en      = 1'b1;
                            wr_row     = upd_row;
                            res_next   = rrte_pkg::make_word(rrte_pkg::ST_OK, upd_row,
                                                             1'b1, 1'b0, 1'b1);
                            state_next = S_FIN;
                        end
                    end
                    rrte_pkg::OP_TIMEOUT:
                    begin
                        if (match)
                        begin
                            wr_en       = 1'b1;
                            wr_row.hops = rrte_pkg::UNREACH;
                            if (!hit_reg)
                            begin
                                hit_next     = 1'b1;
                                hit_row_next = rd_row_reg;
                            end
                        end
                    end
                    default:
                    begin
                        if (send)
                        begin
                            if (pend_valid_reg && !out_free)
                            begin
                                state_next = S_CHK;
                                scan_next  = scan_reg;
                            end
                            else
                            begin
                                if (pend_valid_reg)
                                begin
                                    ovalid_next = 1'b1;
                                    oword_next  = rrte_pkg::make_word(rrte_pkg::ST_OK,
                                                      pend_row_reg, 1'b1, pend_end_reg, 1'b0);
                                end
                                pend_valid_next = 1'b1;
                                pend_row_next   = rd_row_reg;
                                pend_end_next   = pc1 >= PW'(ENTRIES_PER_PACKET);
                                pkt_next        = pend_end_next ? '0 : pc1;
                            end
                        end
                    end
                endcase
            end
            S_END:
            begin
                unique case (op_reg.op)
                    rrte_pkg::OP_UPDATE:
                    begin
                        state_next = S_FIN;
                        if (count_reg == CW'(TABLE_DEPTH))
                            res_next = rrte_pkg::make_word(rrte_pkg::ST_FULL, '0,
                                                           1'b0, 1'b0, 1'b1);
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_row     = op_reg.row;
                            count_next = count_reg + CW'(1);
                            res_next   = rrte_pkg::make_word(rrte_pkg::ST_OK, op_reg.row,
                                                             1'b1, 1'b0, 1'b1);
                        end
                    end
                    rrte_pkg::OP_TIMEOUT:
                    begin
                        state_next        = S_FIN;
                        hit_row_next.hops = rrte_pkg::UNREACH;
                        res_next          = rrte_pkg::make_word(rrte_pkg::ST_OK,
                                                hit_row_next, hit_reg, 1'b0, 1'b1);
                    end
                    default:
                        state_next = S_TAIL;
                endcase
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oword_next  = res_reg;
                    state_next  = S_IDLE;
                end
            end
            S_TAIL:
            begin
                if (!pend_valid_reg)
                    state_next = S_CLOSE;
                else if (out_free)
                begin
                    ovalid_next     = 1'b1;
                    oword_next      = rrte_pkg::make_word(rrte_pkg::ST_OK, pend_row_reg,
                                                          1'b1, 1'b1, !pend_end_reg);
                    pend_valid_next = 1'b0;
                    state_next      = pend_end_reg ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oword_next  = rrte_pkg::make_word(rrte_pkg::ST_OK, '0,
                                                      1'b0, 1'b1, 1'b1);
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pkt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pkt_reg        <= pkt_next;
            pend_valid_reg <= pend_valid_next;
            hit_reg        <= hit_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        scan_reg     <= scan_next;
        pend_end_reg <= pend_end_next;
        pend_row_reg <= pend_row_next;
        hit_row_reg  <= hit_row_next;
        res_reg      <= res_next;
        oword_reg    <= oword_next;
    end

    // route table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
            rd_row_reg <= mem[scan_reg];
        if (wr_en)
            mem[wr_addr] <= wr_row;
    end

endmodule

// ===== sv/rip_route_table_engine_unit.sv =====
`timescale 1ns / 1ps
// channel | valid    | stall     | word
// input   | in_valid | in_stall  | in_data  (rrte_pkg::in_word_t)
// output  | out_valid| out_stall | out_data (rrte_pkg::out_word_t)
//
// an item is worked through entry by entry: the table scan reads each entry in a read
// state and checks it in a check state, through the single read port of the route memory
// a dump gives one word per sent route plus possibly one closing word
// reset clears the entry count and all handshake state; no clearing pass
// output stalls hold the back end; the front register and a two-word queue
// keep taking items while the back end works
module rip_route_table_engine_unit
#(
    parameter int TABLE_DEPTH        = rrte_pkg::TABLE_DEPTH_DEF,
    parameter int ENTRIES_PER_PACKET = rrte_pkg::ENTRIES_PER_PACKET_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rrte_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rrte_pkg::out_word_t out_data
);

    logic          push_valid;
    logic          push_ready;
    rrte_pkg::op_t push_data;
    logic          q_valid;
    logic          q_pop;
    rrte_pkg::op_t q_data;

    rrte_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rrte_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    rrte_back
    #(
        .TABLE_DEPTH        (TABLE_DEPTH),
        .ENTRIES_PER_PACKET (ENTRIES_PER_PACKET)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== sv/rrte_checker.sv =====
`timescale 1ns / 1ps
`include "rip_route_table_engine_unit_assert.svh"
module rrte_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input rrte_pkg::in_word_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input rrte_pkg::out_word_t out_data
);

    `RRTE_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))
    `RRTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `RRTE_ASSERT_NOW(a_no_route_zero, out_valid && !out_data.out_valid,
        out_data.out_dest == 32'd0 && out_data.out_mask == 32'd0
        && out_data.out_nexthop == 32'd0 && out_data.out_metric == 5'd0)
    `RRTE_ASSERT_NOW(a_err_single, out_valid && out_data.status != rrte_pkg::ST_OK,
        out_data.last && !out_data.out_valid && !out_data.packet_end)
    `RRTE_ASSERT_NOW(a_metric_range, out_valid && out_data.out_valid,
        out_data.out_metric <= rrte_pkg::UNREACH)

endmodule

bind rip_route_table_engine_unit rrte_checker u_rrte_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== sim/rrte_checker.sv =====
`timescale 1ns / 1ps
module rrte_scoreboard
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  rrte_pkg::in_word_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  rrte_pkg::out_word_t out_data,
    output int                  fail_count,
    output int                  pending
);
    import rrte_pkg::*;

    localparam int DEPTH = 32;
    localparam int PKT   = 25;

    logic [31:0] tbl_dest [DEPTH];
    logic [31:0] tbl_mask [DEPTH];
    logic [31:0] tbl_hop  [DEPTH];
    logic [4:0]  tbl_hops [DEPTH];
    logic [7:0]  tbl_if   [DEPTH];
    int          n_routes;
    out_word_t   expected_words [$];

    function automatic out_word_t route_word(logic [1:0] st, int idx, logic pend, logic lst);
        out_word_t w;
        w = '0;
        w.status = st;
        if (idx >= 0)
        begin
            w.out_dest    = tbl_dest[idx];
            w.out_mask    = tbl_mask[idx];
            w.out_nexthop = tbl_hop[idx];
            w.out_metric  = tbl_hops[idx];
            w.out_valid   = 1'b1;
        end
        w.packet_end = pend;
        w.last       = lst;
        return w;
    endfunction

    task automatic push_dump(logic [7:0] ifc);
        int cnt;
        out_word_t w;
        cnt = 0;
        for (int i = n_routes - 1; i >= 0; i--)
        begin
            if (tbl_if[i] != ifc)
            begin
                cnt++;
                w = route_word(ST_OK, i, cnt >= PKT, 1'b0);
                if (cnt >= PKT)
                    cnt = 0;
                expected_words.push_back(w);
            end
        end
        if (cnt == 0)
            expected_words.push_back(route_word(ST_OK, -1, 1'b1, 1'b1));
        else
        begin
            w = expected_words.pop_back();
            w.packet_end = 1'b1;
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endtask

    task automatic predict_routes(in_word_t x);
        int idx;
        logic [32:0] met1;
        idx = -1;
        met1 = {1'b0, x.route_metric} + 33'd1;
        if (x.req_type == REQ_RX)
        begin
            if (x.rip_version != RIP_VER)
                expected_words.push_back(route_word(ST_VER_ERR, -1, 1'b0, 1'b1));
            else if (x.rip_command != CMD_REQ && x.rip_command != CMD_RESP)
                expected_words.push_back(route_word(ST_CMD_ERR, -1, 1'b0, 1'b1));
            else if (x.rip_command == CMD_REQ)
                push_dump(x.iface);
            else
            begin
                for (int i = n_routes - 1; i >= 0 && idx < 0; i--)
                    if (tbl_dest[i] == x.dest_addr && tbl_mask[i] == x.dest_mask)
                        idx = i;
                if (idx >= 0)
                begin
                    if (x.route_metric >= 32'd16)
                        tbl_hops[idx] = UNREACH;
                    else if (met1 < {28'd0, tbl_hops[idx]})
                    begin
                        tbl_hop[idx]  = x.src_addr;
                        tbl_hops[idx] = met1[4:0];
                        tbl_if[idx]   = x.iface;
                    end
                    expected_words.push_back(route_word(ST_OK, idx, 1'b0, 1'b1));
                end
                else if (n_routes >= DEPTH)
                    expected_words.push_back(route_word(ST_FULL, -1, 1'b0, 1'b1));
                else
                begin
                    idx = n_routes;
                    tbl_dest[idx] = x.dest_addr;
                    tbl_mask[idx] = x.dest_mask;
                    tbl_hop[idx]  = x.src_addr;
                    tbl_hops[idx] = (x.route_metric >= 32'd16) ? UNREACH : met1[4:0];
                    tbl_if[idx]   = x.iface;
                    n_routes++;
                    expected_words.push_back(route_word(ST_OK, idx, 1'b0, 1'b1));
                end
            end
        end
        else if (x.req_type == REQ_TIMEOUT)
        begin
            for (int i = n_routes - 1; i >= 0; i--)
                if (tbl_dest[i] == x.dest_addr && tbl_mask[i] == x.dest_mask)
                begin
                    tbl_hops[i] = UNREACH;
                    if (idx < 0)
                        idx = i;
                end
            expected_words.push_back(route_word(ST_OK, idx, 1'b0, 1'b1));
        end
        else if (x.req_type == REQ_SEND)
            push_dump(x.iface);
        else
            expected_words.push_back(route_word(ST_OK, -1, 1'b0, 1'b1));
    endtask

    assign pending = expected_words.size();

    initial
    begin
        fail_count = 0;
        n_routes = 0;
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (out_data.status !== e.status || out_data.out_dest !== e.out_dest
                        || out_data.out_mask !== e.out_mask
                        || out_data.out_nexthop !== e.out_nexthop
                        || out_data.out_metric !== e.out_metric
                        || out_data.out_valid !== e.out_valid
                        || out_data.packet_end !== e.packet_end
                        || out_data.last !== e.last)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_routes(in_data);
        end
    end
endmodule

// ===== sim/tb_rip_route_table_engine_unit.sv =====
`timescale 1ns / 1ps
module tb_rip_route_table_engine_unit;
    import rrte_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;
    int        fail_count;
    int        pending;
    int        cycle_count;
    bit        calm;
    bit        hold_out;
    bit        sent_all;

    logic [31:0] known_dest [8];
    logic [31:0] known_mask [8];

    rip_route_table_engine_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    rrte_scoreboard checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (hold_out)
            out_stall <= 1'b1;
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 35);
    end

    function automatic in_word_t make_item(logic [1:0] rt, logic [7:0] ver, logic [7:0] cmd,
                                           logic [31:0] d, logic [31:0] m, logic [31:0] met,
                                           logic [31:0] s, logic [7:0] ifc);
        in_word_t x;
        x.req_type = rt;
        x.rip_version = ver;
        x.rip_command = cmd;
        x.dest_addr = d;
        x.dest_mask = m;
        x.route_metric = met;
        x.src_addr = s;
        x.iface = ifc;
        return x;
    endfunction

    task automatic send_word(in_word_t x);
        if (!calm)
            while ($urandom_range(99) < 35)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        in_data  <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic in_word_t random_item();
        int k;
        int p;
        logic [31:0] met;
        k = $urandom_range(7);
        p = $urandom_range(99);
        met = ($urandom_range(3) == 0) ? $urandom : $urandom_range(17);
        if (p < 55)
        begin
            if ($urandom_range(1))
                return make_item(REQ_RX, RIP_VER, CMD_RESP, known_dest[k], known_mask[k], met,
                                 $urandom, 8'($urandom_range(3)));
            return make_item(REQ_RX, RIP_VER, CMD_RESP, $urandom, $urandom, met, $urandom,
                             8'($urandom_range(3)));
        end
        if (p < 65)
            return make_item(REQ_TIMEOUT, 8'($urandom), 8'($urandom), known_dest[k],
                             known_mask[k], $urandom, $urandom, 8'($urandom));
        if (p < 75)
            return make_item(REQ_SEND, 8'($urandom), 8'($urandom), $urandom, $urandom,
                             $urandom, $urandom,
                             ($urandom_range(1)) ? 8'($urandom_range(3)) : 8'($urandom));
        if (p < 82)
            return make_item(REQ_RX, RIP_VER, CMD_REQ, $urandom, $urandom, $urandom,
                             $urandom, 8'($urandom_range(3)));
        if (p < 92)
            return make_item(REQ_RX, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom,
                             $urandom, 8'($urandom));
        return make_item(2'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom,
                         $urandom, $urandom, 8'($urandom));
    endfunction

    initial
    begin
        in_word_t x;
        cycle_count = 0;
        calm = 1'b0;
        hold_out = 1'b0;
        sent_all = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            known_dest[i] = $urandom;
            known_mask[i] = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'd0 : $urandom;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_word(make_item(REQ_SEND, 8'd0, 8'd0, 0, 0, 0, 0, 8'd0));
        send_word(make_item(REQ_RX, RIP_VER, CMD_REQ, 0, 0, 0, 0, 8'hFF));
        send_word(make_item(REQ_RX, 8'hFF, CMD_RESP, '1, '1, '1, '1, 8'hFF));
        send_word(make_item(REQ_RX, 8'd0, CMD_RESP, 0, 0, 0, 0, 8'd0));
        send_word(make_item(REQ_RX, RIP_VER, 8'd0, '1, '1, '1, '1, 8'hFF));
        send_word(make_item(REQ_RX, RIP_VER, 8'hFF, 0, 0, 0, 0, 8'd0));
        send_word(make_item(REQ_RX, RIP_VER, CMD_RESP, known_dest[0], known_mask[0], 32'd5,
                            32'h0A00_0001, 8'd1));
        send_word(make_item(REQ_RX, RIP_VER, CMD_RESP, known_dest[0], known_mask[0], 32'd2,
                            32'h0A00_0002, 8'd2));
        send_word(make_item(REQ_RX, RIP_VER, CMD_RESP, known_dest[0], known_mask[0], 32'd9,
                            32'h0A00_0003, 8'd3));
        send_word(make_item(REQ_RX, RIP_VER, CMD_RESP, known_dest[0], known_mask[0], '1,
                            '1, 8'd3));
        send_word(make_item(REQ_RX, RIP_VER, CMD_RESP, known_dest[1], known_mask[1], '1,
                            '1, 8'hFF));
        send_word(make_item(REQ_RX, RIP_VER, CMD_RESP, known_dest[2], known_mask[2], 32'd0,
                            32'd0, 8'd0));
        send_word(make_item(REQ_RX, RIP_VER, CMD_RESP, known_dest[3], known_mask[3], 32'd15,
                            32'h1234_5678, 8'd1));
        send_word(make_item(REQ_TIMEOUT, 8'd0, 8'd0, known_dest[2], known_mask[2], 0, 0, 8'd0));
        send_word(make_item(REQ_TIMEOUT, 8'd0, 8'd0, '1, '1, 0, 0, 8'd0));
        send_word(make_item(2'd3, '1, '1, '1, '1, '1, '1, '1));
        send_word(make_item(REQ_SEND, 8'd0, 8'd0, 0, 0, 0, 0, 8'd1));
        send_word(make_item(REQ_RX, RIP_VER, CMD_REQ, 0, 0, 0, 0, 8'd7));

        // fill past capacity, then dump to cross a packet boundary
        for (int i = 0; i < 34; i++)
            send_word(make_item(REQ_RX, RIP_VER, CMD_RESP, $urandom, $urandom,
                                $urandom_range(20), $urandom, 8'($urandom_range(3))));
        send_word(make_item(REQ_SEND, 8'd0, 8'd0, 0, 0, 0, 0, 8'd9));

        // sender pauses until drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // long receiver hold while items keep coming
        hold_out = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_out = 1'b0;
            end
            for (int i = 0; i < 10; i++)
                send_word(random_item());
        join

        for (int i = 0; i < 70; i++)
        begin
            calm = (i >= 25 && i < 50);
            send_word(random_item());
        end
        calm = 1'b0;
        sent_all = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
